// ===== design/nps_pkg.sv =====
// nps_pkg: shared constants, codes and controller/datapath interface types
// for the nearest palette color search block
// no dependencies
package nps_pkg;

    localparam int PAL_ENTRIES = 256;   // entries scanned by a query, 2..256
    localparam int STORE_DEPTH = 256;   // entries addressable by entry_index
    localparam int COLOR_W     = 8;
    localparam int IDX_W       = 8;
    localparam int ENTRY_W     = 3 * COLOR_W;
    localparam int DIFF_SQ_W   = 2 * COLOR_W;
    localparam int RSUM_W      = COLOR_W + 1;
    localparam int WEIGHT_W    = 11;
    localparam int PROD_W      = 28;
    localparam int DIST_W      = 29;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAL_ENTRIES - 1);

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // distance modes
    localparam logic MODE_EUCLID  = 1'b0;
    localparam logic MODE_REDMEAN = 1'b1;

    // redmean weights, metric scaled by 510
    localparam logic [WEIGHT_W-1:0] W_RED_BASE  = WEIGHT_W'(1020);
    localparam logic [WEIGHT_W-1:0] W_GREEN     = WEIGHT_W'(2040);
    localparam logic [WEIGHT_W-1:0] W_BLUE_BASE = WEIGHT_W'(1530);
    localparam logic [WEIGHT_W-1:0] W_UNIT      = WEIGHT_W'(1);

    typedef struct packed {
        logic write;        // store one palette entry from the input fields
        logic start;        // latch query color, reset scan address
        logic issue;        // read one palette entry into the pipeline
        logic load_result;  // move best match into the output register
    } nps_cmd_t;

    typedef struct packed {
        logic last_addr;    // scan address is the last palette entry
        logic pipe_busy;    // some entry still in the distance pipeline
        logic out_free;     // output register can take a new result
    } nps_sts_t;

endpackage

// ===== design/nps_ctrl.sv =====
// nps_ctrl: controller state machine for the palette search
// sequences input transactions, the entry scan, drain and result load
// depends on nps_pkg
module nps_ctrl
    import nps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     req_type,
    output logic     in_stall,
    input  nps_sts_t sts,
    output nps_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        state_next      = state_reg;
        cmd.write       = 1'b0;
        cmd.start       = 1'b0;
        cmd.issue       = 1'b0;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == REQ_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last distance, then for room at the output
                if (!sts.pipe_busy && sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_state_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    a_scan_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_SCAN) |-> $past(cmd.start))
        else $error("scan entered without a query transaction");

    a_scan_leaves_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && !sts.last_addr |=> (state_reg == ST_SCAN))
        else $error("scan ended before the last palette entry");

endmodule

// ===== design/nps_datapath.sv =====
// nps_datapath: palette store, distance pipeline, best-match tracking
// and output register for the palette search
// depends on nps_pkg
module nps_datapath
    import nps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  nps_cmd_t           cmd,
    output nps_sts_t           sts,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic [IDX_W-1:0]   entry_index,
    input  logic [COLOR_W-1:0] red,
    input  logic [COLOR_W-1:0] green,
    input  logic [COLOR_W-1:0] blue,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [IDX_W-1:0]   nearest_index,
    output logic [DIST_W-1:0]  min_distance
);

    logic mode_reg;

    // palette store, valid bits make unwritten entries read as black
    logic [ENTRY_W-1:0]     pal_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] pal_ok_reg;
    logic                   wr_in_range;

    logic [COLOR_W-1:0] q_r_reg, q_g_reg, q_b_reg;
    logic [IDX_W-1:0]   addr_reg;

    // stage 1: read
    logic               v1_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_ok_reg;

    // stage 2: squared differences and weights
    logic [COLOR_W-1:0]   e_r, e_g, e_b;
    logic [COLOR_W-1:0]   d_r, d_g, d_b;
    logic [RSUM_W-1:0]    rsum;
    logic                 v2_reg;
    logic [IDX_W-1:0]     idx2_reg;
    logic [DIFF_SQ_W-1:0] sq_r_reg, sq_g_reg, sq_b_reg;
    logic [WEIGHT_W-1:0]  w_r_reg, w_g_reg, w_b_reg;

    // stage 3: weighted products
    logic              v3_reg;
    logic [IDX_W-1:0]  idx3_reg;
    logic [PROD_W-1:0] p_r_reg, p_g_reg, p_b_reg;

    // stage 4: distance
    logic              v4_reg;
    logic [IDX_W-1:0]  idx4_reg;
    logic [DIST_W-1:0] dist_reg;

    logic [IDX_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [DIST_W-1:0] out_dist_reg;

    assign wr_in_range = ({1'b0, entry_index} < (IDX_W + 1)'(PAL_ENTRIES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_EUCLID;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_in_range)
        begin
            pal_mem[entry_index] <= {red, green, blue};
        end
        if (cmd.issue)
        begin
            rd_data_reg <= pal_mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_ok_reg <= '0;
        end
        else if (cmd.write && wr_in_range)
        begin
            pal_ok_reg[entry_index] <= 1'b1;
        end
    end

    // query color and scan address
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            q_r_reg <= red;
            q_g_reg <= green;
            q_b_reg <= blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cmd.start)
        begin
            addr_reg <= '0;
        end
        else if (cmd.issue)
        begin
            addr_reg <= addr_reg + IDX_W'(1);
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg  <= addr_reg;
        rd_ok_reg <= pal_ok_reg[addr_reg];
        idx2_reg  <= idx1_reg;
        idx3_reg  <= idx2_reg;
        idx4_reg  <= idx3_reg;
    end

    always_comb
    begin
        e_r  = rd_ok_reg ? rd_data_reg[ENTRY_W-1 -: COLOR_W] : '0;
        e_g  = rd_ok_reg ? rd_data_reg[ENTRY_W-COLOR_W-1 -: COLOR_W] : '0;
        e_b  = rd_ok_reg ? rd_data_reg[COLOR_W-1:0] : '0;
        d_r  = (q_r_reg >= e_r) ? (q_r_reg - e_r) : (e_r - q_r_reg);
        d_g  = (q_g_reg >= e_g) ? (q_g_reg - e_g) : (e_g - q_g_reg);
        d_b  = (q_b_reg >= e_b) ? (q_b_reg - e_b) : (e_b - q_b_reg);
        rsum = RSUM_W'(q_r_reg) + RSUM_W'(e_r);
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg <= DIFF_SQ_W'(d_r) * DIFF_SQ_W'(d_r);
        sq_g_reg <= DIFF_SQ_W'(d_g) * DIFF_SQ_W'(d_g);
        sq_b_reg <= DIFF_SQ_W'(d_b) * DIFF_SQ_W'(d_b);
        if (mode_reg == MODE_REDMEAN)
        begin
            w_r_reg <= W_RED_BASE + WEIGHT_W'(rsum);
            w_g_reg <= W_GREEN;
            w_b_reg <= W_BLUE_BASE - WEIGHT_W'(rsum);
        end
        else
        begin
            w_r_reg <= W_UNIT;
            w_g_reg <= W_UNIT;
            w_b_reg <= W_UNIT;
        end
        p_r_reg  <= PROD_W'(sq_r_reg) * PROD_W'(w_r_reg);
        p_g_reg  <= PROD_W'(sq_g_reg) * PROD_W'(w_g_reg);
        p_b_reg  <= PROD_W'(sq_b_reg) * PROD_W'(w_b_reg);
        dist_reg <= DIST_W'(p_r_reg) + DIST_W'(p_g_reg) + DIST_W'(p_b_reg);
    end

    // running minimum, strict compare keeps the lowest index on a tie
    always_ff @(posedge clk)
    begin
        if (v4_reg && ((idx4_reg == '0) || (dist_reg < best_dist_reg)))
        begin
            best_idx_reg  <= idx4_reg;
            best_dist_reg <= dist_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_idx_reg  <= best_idx_reg;
            out_dist_reg <= best_dist_reg;
        end
    end

    assign sts.last_addr = (addr_reg == LAST_IDX);
    assign sts.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign nearest_index = out_idx_reg;
    assign min_distance  = out_dist_reg;

    a_read_needs_issue: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> $past(cmd.issue))
        else $error("pipeline entry without a read");

    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> !sts.pipe_busy && sts.out_free)
        else $error("result loaded while scan in flight or output full");

    a_best_never_grows: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && (idx4_reg != '0) |=> (best_dist_reg <= $past(best_dist_reg)))
        else $error("best distance increased during a scan");

endmodule

// ===== design/nearest_palette_color_search_top.sv =====
// nearest_palette_color_search_top: top level of the palette search block
// joins the controller and the datapath; depends on nps_pkg, nps_ctrl, nps_datapath
//
//   channel  handshake             payload
//   ------   --------------------  ---------------------------------------------
//   in       in_valid / in_stall   req_type, entry_index, red, green, blue
//   out      out_valid / out_stall nearest_index, min_distance
//   cfg      cfg_wr_en             cfg_wr_data (distance_mode)
//
// a write transaction is taken at once and leaves the block idle; a query holds the input
// (in_stall) through the scan and the drain until its result is loaded into the output register:
// one palette read per cycle from the single store port, then a four-stage
// distance pipeline drains before the result is loaded
// reset clears the mode, the valid bits of the store and all control state;
// no clearing pass is needed, unwritten entries read as black
// the output register holds a result under out_stall while new transactions
// are taken; a finished query waits only if the previous result is still held
module nearest_palette_color_search_top
    import nps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [IDX_W-1:0]   entry_index,
    input  logic [COLOR_W-1:0] red,
    input  logic [COLOR_W-1:0] green,
    input  logic [COLOR_W-1:0] blue,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [IDX_W-1:0]   nearest_index,
    output logic [DIST_W-1:0]  min_distance
);

    nps_cmd_t cmd;
    nps_sts_t sts;

    nps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    nps_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .nearest_index (nearest_index),
        .min_distance  (min_distance)
    );

endmodule

// ===== verif/nearest_palette_color_search_top_test.sv =====
// nearest_palette_color_search_top_test: self-checking testbench for the palette search top
// directed table plus random phases in both distance modes, scored against a behavioral palette
// depends on nps_pkg and nearest_palette_color_search_top
module nearest_palette_color_search_top_test
    import nps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_QUERY,
        STEP_KNOWN,
        STEP_MODE
    } step_kind_t;

    typedef struct packed {
        step_kind_t         kind;
        logic               mode;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic [IDX_W-1:0]   exp_idx;
        logic [DIST_W-1:0]  exp_dist;
    } step_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] distance;
    } match_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [IDX_W-1:0]   nearest_index;
    logic [DIST_W-1:0]  min_distance;

    logic [ENTRY_W-1:0] palette_model [PAL_ENTRIES];
    logic               mode_model;
    match_t             pending_matches [$];

    int fail_count    = 0;
    int burst_left    = 0;
    int n_writes      = 0;
    int n_euclid_q    = 0;
    int n_redmean_q   = 0;
    int n_results     = 0;
    int n_mode_writes = 0;

    // first rows rely on the all-black palette after reset
    step_t directed_steps [23] = '{
        '{STEP_KNOWN, MODE_EUCLID,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   29'd0},
        '{STEP_KNOWN, MODE_EUCLID,  8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   29'd195075},
        '{STEP_MODE,  MODE_REDMEAN, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   29'd0},
        '{STEP_KNOWN, MODE_EUCLID,  8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   29'd298464750},
        '{STEP_KNOWN, MODE_EUCLID,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   29'd0},
        '{STEP_WRITE, MODE_EUCLID,  8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   29'd0},
        '{STEP_KNOWN, MODE_EUCLID,  8'd17,  8'd255, 8'd255, 8'd255, 8'd255, 29'd0},
        '{STEP_WRITE, MODE_EUCLID,  8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   29'd0},
        '{STEP_KNOWN, MODE_EUCLID,  8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   29'd0},
        '{STEP_KNOWN, MODE_EUCLID,  8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   29'd0},
        '{STEP_QUERY, MODE_EUCLID,  8'd3,   8'd200, 8'd10,  8'd90,  8'd0,   29'd0},
        '{STEP_WRITE, MODE_EUCLID,  8'd170, 8'hAA,  8'h55,  8'hAA,  8'd0,   29'd0},
        '{STEP_WRITE, MODE_EUCLID,  8'd85,  8'h55,  8'hAA,  8'h55,  8'd0,   29'd0},
        '{STEP_KNOWN, MODE_EUCLID,  8'd0,   8'hAA,  8'h55,  8'hAA,  8'd170, 29'd0},
        '{STEP_QUERY, MODE_EUCLID,  8'd0,   8'hA0,  8'h60,  8'hA0,  8'd0,   29'd0},
        '{STEP_MODE,  MODE_EUCLID,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   29'd0},
        '{STEP_QUERY, MODE_EUCLID,  8'd85,  8'h55,  8'hAA,  8'h55,  8'd0,   29'd0},
        '{STEP_QUERY, MODE_EUCLID,  8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   29'd0},
        '{STEP_WRITE, MODE_EUCLID,  8'd1,   8'd1,   8'd2,   8'd3,   8'd0,   29'd0},
        '{STEP_KNOWN, MODE_EUCLID,  8'd0,   8'd0,   8'd0,   8'd0,   8'd2,   29'd0},
        '{STEP_QUERY, MODE_EUCLID,  8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   29'd0},
        '{STEP_WRITE, MODE_EUCLID,  8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   29'd0},
        '{STEP_QUERY, MODE_EUCLID,  8'd0,   8'd127, 8'd128, 8'd129, 8'd0,   29'd0}
    };

    nearest_palette_color_search_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .nearest_index (nearest_index),
        .min_distance  (min_distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // redmean is kept scaled by 510 so every distance is an exact integer
    function automatic logic [DIST_W-1:0] palette_distance(
        input logic               mode,
        input logic [COLOR_W-1:0] r,
        input logic [COLOR_W-1:0] g,
        input logic [COLOR_W-1:0] b,
        input logic [ENTRY_W-1:0] entry
    );
        int unsigned er;
        int unsigned eg;
        int unsigned eb;
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        int unsigned rsum;
        er = entry[23:16];
        eg = entry[15:8];
        eb = entry[7:0];
        dr = (r > er) ? r - er : er - r;
        dg = (g > eg) ? g - eg : eg - g;
        db = (b > eb) ? b - eb : eb - b;
        rsum = r + er;
        if (mode == MODE_EUCLID)
            return DIST_W'(dr * dr + dg * dg + db * db);
        return DIST_W'(dr * dr * (1020 + rsum) + 2040 * dg * dg + db * db * (1530 - rsum));
    endfunction

    function automatic match_t nearest_match(
        input logic [COLOR_W-1:0] r,
        input logic [COLOR_W-1:0] g,
        input logic [COLOR_W-1:0] b
    );
        match_t            best;
        logic [DIST_W-1:0] d;
        best = '0;
        for (int i = 0; i < PAL_ENTRIES; i++)
        begin
            d = palette_distance(mode_model, r, g, b, palette_model[i]);
            // strict compare keeps the lowest index on a tie
            if (i == 0 || d < best.distance)
            begin
                best.index    = IDX_W'(i);
                best.distance = d;
            end
        end
        return best;
    endfunction

    function automatic logic [COLOR_W-1:0] nudge(input logic [COLOR_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return COLOR_W'(v);
    endfunction

    task automatic send_item(
        input logic               req,
        input logic [IDX_W-1:0]   idx,
        input logic [COLOR_W-1:0] r,
        input logic [COLOR_W-1:0] g,
        input logic [COLOR_W-1:0] b,
        input bit                 known,
        input match_t             known_match
    );
        int     gap;
        match_t m;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = 0;
                9:             gap = $urandom_range(9, 300);
                default:       gap = $urandom_range(1, 8);
            endcase
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        entry_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (req == REQ_WRITE)
        begin
            if (idx < PAL_ENTRIES)
                palette_model[idx] = {r, g, b};
            n_writes++;
        end
        else
        begin
            m = known ? known_match : nearest_match(r, g, b);
            pending_matches.push_back(m);
            if (mode_model == MODE_EUCLID)
                n_euclid_q++;
            else
                n_redmean_q++;
        end
    endtask

    // mode changes only with the block drained, after any trailing write as well
    task automatic set_mode(input logic mode);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mode_model = mode;
        n_mode_writes++;
    endtask

    // receiver stalls on its own schedule, switching style every so often
    always @(negedge clk)
    begin : stall_pattern
        static int style      = 0;
        static int style_left = 0;
        if (style_left == 0)
        begin
            style      = $urandom_range(0, 3);
            style_left = $urandom_range(20, 400);
        end
        style_left--;
        case (style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((style_left % 5) < 2);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        match_t m;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_matches.size() == 0)
            begin
                $error("result transaction with no query pending: index %0d distance %0d",
                       nearest_index, min_distance);
                fail_count++;
            end
            else
            begin
                m = pending_matches.pop_front();
                if (nearest_index !== m.index)
                begin
                    $error("nearest_index: expected %0d, got %0d", m.index, nearest_index);
                    fail_count++;
                end
                if (min_distance !== m.distance)
                begin
                    $error("min_distance: expected %0d, got %0d", m.distance, min_distance);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        step_t              s;
        match_t             m;
        match_t             none;
        logic [ENTRY_W-1:0] e;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic               mode;
        none        = '0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = MODE_EUCLID;
        in_valid    = 1'b0;
        req_type    = REQ_WRITE;
        entry_index = '0;
        red         = '0;
        green       = '0;
        blue        = '0;
        mode_model  = MODE_EUCLID;
        foreach (palette_model[i])
            palette_model[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[k])
        begin
            s = directed_steps[k];
            m.index    = s.exp_idx;
            m.distance = s.exp_dist;
            case (s.kind)
                STEP_MODE:  set_mode(s.mode);
                STEP_WRITE: send_item(REQ_WRITE, s.idx, s.r, s.g, s.b, 1'b0, none);
                STEP_QUERY: send_item(REQ_QUERY, s.idx, s.r, s.g, s.b, 1'b0, none);
                default:    send_item(REQ_QUERY, s.idx, s.r, s.g, s.b, 1'b1, m);
            endcase
        end

        for (int p = 0; p < 5; p++)
        begin
            if (p < 3)
                mode = (p % 2 == 0) ? MODE_REDMEAN : MODE_EUCLID;
            else
                mode = $urandom_range(0, 1) ? MODE_REDMEAN : MODE_EUCLID;
            set_mode(mode);
            for (int k = 0; k < 126; k++)
            begin
                e   = palette_model[$urandom_range(0, PAL_ENTRIES - 1)];
                idx = IDX_W'($urandom);
                r   = COLOR_W'($urandom);
                g   = COLOR_W'($urandom);
                b   = COLOR_W'($urandom);
                if ($urandom_range(0, 1) == 0)
                begin
                    // duplicated colors give ties at scattered indexes
                    if ($urandom_range(0, 3) == 0)
                        {r, g, b} = e;
                    send_item(REQ_WRITE, idx, r, g, b, 1'b0, none);
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        4, 5, 6:
                        begin
                            r = nudge(e[23:16]);
                            g = nudge(e[15:8]);
                            b = nudge(e[7:0]);
                        end
                        7, 8: {r, g, b} = e;
                        9:
                        begin
                            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        end
                        default: ;
                    endcase
                    send_item(REQ_QUERY, idx, r, g, b, 1'b0, none);
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("covered %0d palette writes, %0d euclidean and %0d redmean queries",
                 n_writes, n_euclid_q, n_redmean_q);
        $display("%0d results scored, %0d mode register writes, %0d mismatches",
                 n_results, n_mode_writes, fail_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
